[design/tpfb_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and font for the text-to-page frame buffer.
// No dependencies.
package tpfb_pkg;

    localparam int PANEL_WIDTH   = 128;
    localparam int PANEL_HEIGHT  = 64;
    localparam int GLYPH_HEIGHT  = 8;
    localparam int GLYPH_ADVANCE = 6;
    localparam int GLYPH_COLS    = 5;
    localparam int STORE_DEPTH   = 1024;
    localparam int STORE_WIDTH   = 8;
    localparam int ADDR_W        = $clog2(STORE_DEPTH);
    localparam int GLYPHS        = 70;
    localparam int GIDX_W        = $clog2(GLYPHS);

    localparam logic [1:0] OP_DRAW   = 2'd0;
    localparam logic [1:0] OP_CLEAR  = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [GIDX_W-1:0] G_DIGIT0   = GIDX_W'(0);
    localparam logic [GIDX_W-1:0] G_UPPER_A  = GIDX_W'(10);
    localparam logic [GIDX_W-1:0] G_LOWER_A  = GIDX_W'(36);
    localparam logic [GIDX_W-1:0] G_PLUS     = GIDX_W'(62);
    localparam logic [GIDX_W-1:0] G_MINUS    = GIDX_W'(63);
    localparam logic [GIDX_W-1:0] G_DOT      = GIDX_W'(64);
    localparam logic [GIDX_W-1:0] G_SLASH    = GIDX_W'(65);
    localparam logic [GIDX_W-1:0] G_COLON    = GIDX_W'(66);
    localparam logic [GIDX_W-1:0] G_UNDER    = GIDX_W'(67);
    localparam logic [GIDX_W-1:0] G_QUEST    = GIDX_W'(68);
    localparam logic [GIDX_W-1:0] G_SPACE    = GIDX_W'(69);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_RD_REQ,
        ST_RD_OUT,
        ST_DRAW_RD,
        ST_DRAW_WR
    } tpfb_state_t;

    typedef struct packed {
        logic accept;
        logic clr_wr;
        logic rd_req;
        logic rd_draw;
        logic wr_draw;
        logic out_load;
        logic step;
    } tpfb_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       go;
        logic       clr_last;
        logic       draw_last;
        logic       mask_zero;
        logic       out_free;
    } tpfb_status_t;

    localparam logic [7:0] FONT [GLYPHS][GLYPH_COLS] = '{
        '{8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E}, '{8'h00, 8'h42, 8'h7F, 8'h40, 8'h00},
        '{8'h42, 8'h61, 8'h51, 8'h49, 8'h46}, '{8'h21, 8'h41, 8'h45, 8'h4B, 8'h31},
        '{8'h18, 8'h14, 8'h12, 8'h7F, 8'h10}, '{8'h27, 8'h45, 8'h45, 8'h45, 8'h39},
        '{8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30}, '{8'h01, 8'h71, 8'h09, 8'h05, 8'h03},
        '{8'h36, 8'h49, 8'h49, 8'h49, 8'h36}, '{8'h06, 8'h49, 8'h49, 8'h29, 8'h1E},
        '{8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E}, '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h36},
        '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h22}, '{8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C},
        '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h41}, '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h01},
        '{8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A}, '{8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F},
        '{8'h00, 8'h41, 8'h7F, 8'h41, 8'h00}, '{8'h20, 8'h40, 8'h41, 8'h3F, 8'h01},
        '{8'h7F, 8'h08, 8'h14, 8'h22, 8'h41}, '{8'h7F, 8'h40, 8'h40, 8'h40, 8'h40},
        '{8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F}, '{8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F},
        '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E}, '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h06},
        '{8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E}, '{8'h7F, 8'h09, 8'h19, 8'h29, 8'h46},
        '{8'h46, 8'h49, 8'h49, 8'h49, 8'h31}, '{8'h01, 8'h01, 8'h7F, 8'h01, 8'h01},
        '{8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F}, '{8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F},
        '{8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F}, '{8'h63, 8'h14, 8'h08, 8'h14, 8'h63},
        '{8'h07, 8'h08, 8'h70, 8'h08, 8'h07}, '{8'h61, 8'h51, 8'h49, 8'h45, 8'h43},
        '{8'h20, 8'h54, 8'h54, 8'h54, 8'h78}, '{8'h7F, 8'h48, 8'h44, 8'h44, 8'h38},
        '{8'h38, 8'h44, 8'h44, 8'h44, 8'h20}, '{8'h38, 8'h44, 8'h44, 8'h48, 8'h7F},
        '{8'h38, 8'h54, 8'h54, 8'h54, 8'h18}, '{8'h08, 8'h7E, 8'h09, 8'h01, 8'h02},
        '{8'h0C, 8'h52, 8'h52, 8'h52, 8'h3E}, '{8'h7F, 8'h08, 8'h04, 8'h04, 8'h78},
        '{8'h00, 8'h44, 8'h7D, 8'h40, 8'h00}, '{8'h20, 8'h40, 8'h44, 8'h3D, 8'h00},
        '{8'h7F, 8'h10, 8'h28, 8'h44, 8'h00}, '{8'h00, 8'h41, 8'h7F, 8'h40, 8'h00},
        '{8'h7C, 8'h04, 8'h18, 8'h04, 8'h78}, '{8'h7C, 8'h08, 8'h04, 8'h04, 8'h78},
        '{8'h38, 8'h44, 8'h44, 8'h44, 8'h38}, '{8'h7C, 8'h14, 8'h14, 8'h14, 8'h08},
        '{8'h08, 8'h14, 8'h14, 8'h18, 8'h7C}, '{8'h7C, 8'h08, 8'h04, 8'h04, 8'h08},
        '{8'h48, 8'h54, 8'h54, 8'h54, 8'h20}, '{8'h04, 8'h3F, 8'h44, 8'h40, 8'h20},
        '{8'h3C, 8'h40, 8'h40, 8'h20, 8'h7C}, '{8'h1C, 8'h20, 8'h40, 8'h20, 8'h1C},
        '{8'h3C, 8'h40, 8'h30, 8'h40, 8'h3C}, '{8'h44, 8'h28, 8'h10, 8'h28, 8'h44},
        '{8'h0C, 8'h50, 8'h50, 8'h50, 8'h3C}, '{8'h44, 8'h64, 8'h54, 8'h4C, 8'h44},
        '{8'h08, 8'h08, 8'h3E, 8'h08, 8'h08}, '{8'h08, 8'h08, 8'h08, 8'h08, 8'h08},
        '{8'h00, 8'h60, 8'h60, 8'h00, 8'h00}, '{8'h20, 8'h10, 8'h08, 8'h04, 8'h02},
        '{8'h00, 8'h36, 8'h36, 8'h00, 8'h00}, '{8'h40, 8'h40, 8'h40, 8'h40, 8'h40},
        '{8'h02, 8'h01, 8'h51, 8'h09, 8'h06}, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    function automatic logic [GIDX_W-1:0] glyph_index(input logic [7:0] c);
        logic [GIDX_W-1:0] g;
        g = G_QUEST;
        if (c == 8'h20) begin
            g = G_SPACE;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            g = G_DIGIT0 + GIDX_W'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h5A) begin
            g = G_UPPER_A + GIDX_W'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            g = G_LOWER_A + GIDX_W'(c - 8'h61);
        end else if (c == 8'h2B) begin
            g = G_PLUS;
        end else if (c == 8'h2D) begin
            g = G_MINUS;
        end else if (c == 8'h2E) begin
            g = G_DOT;
        end else if (c == 8'h2F) begin
            g = G_SLASH;
        end else if (c == 8'h3A) begin
            g = G_COLON;
        end else if (c == 8'h5F) begin
            g = G_UNDER;
        end
        return g;
    endfunction

endpackage

[design/tpfb_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tpfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule

[design/tpfb_ctrl.sv]
`timescale 1ns / 1ps
// Controller state machine: sequences clears, reads and glyph read-modify-writes.
// Depends on tpfb_pkg.
module tpfb_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  tpfb_pkg::tpfb_status_t sts,
    output tpfb_pkg::tpfb_cmd_t    cmd
);
    import tpfb_pkg::*;

    tpfb_state_t state_reg, state_next;
    logic        acc;

    assign s_ready = (state_reg == ST_IDLE);
    assign acc     = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT, ST_CLEAR: begin
                if (sts.clr_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (acc) begin
                    case (sts.op)
                        OP_CLEAR: state_next = ST_CLEAR;
                        OP_READ:  state_next = ST_RD_REQ;
                        OP_DRAW:  state_next = sts.go ? ST_DRAW_RD : ST_IDLE;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_RD_REQ: state_next = ST_RD_OUT;
            ST_RD_OUT: begin
                if (sts.out_free) state_next = ST_IDLE;
            end
            ST_DRAW_RD: begin
                if (!sts.mask_zero) begin
                    state_next = ST_DRAW_WR;
                end else if (sts.draw_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_DRAW_WR: state_next = sts.draw_last ? ST_IDLE : ST_DRAW_RD;
            default:    state_next = ST_INIT;
        endcase
    end

    always_comb begin
        cmd = '0;
        cmd.accept = acc;
        case (state_reg)
            ST_INIT, ST_CLEAR: cmd.clr_wr = 1'b1;
            ST_RD_REQ:         cmd.rd_req = 1'b1;
            ST_RD_OUT:         cmd.out_load = sts.out_free;
            ST_DRAW_RD: begin
                cmd.rd_draw = !sts.mask_zero;
                cmd.step    = sts.mask_zero;
            end
            ST_DRAW_WR: begin
                cmd.wr_draw = 1'b1;
                cmd.step    = 1'b1;
            end
            default: cmd.accept = acc;
        endcase
    end
endmodule

[design/tpfb_dp.sv]
`timescale 1ns / 1ps
// Datapath: cursor, glyph masks, store addressing, output register.
// Depends on tpfb_pkg and tpfb_ram.
module tpfb_dp (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [1:0]             s_op,
    input  logic                   s_start_string,
    input  logic [7:0]             s_x,
    input  logic [7:0]             s_y,
    input  logic [7:0]             s_char_code,
    input  logic [6:0]             s_read_column,
    input  logic [2:0]             s_read_page,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [7:0]             m_read_byte,
    input  tpfb_pkg::tpfb_cmd_t    cmd,
    output tpfb_pkg::tpfb_status_t sts
);
    import tpfb_pkg::*;

    logic [7:0]        cur_x_reg, cur_x_next;
    logic [7:0]        cur_y_reg, cur_y_next;
    logic              active_reg, active_next;
    logic [7:0]        gx_reg, gy_reg;
    logic [GIDX_W-1:0] gidx_reg;
    logic [2:0]        col_reg, col_next;
    logic              pg_reg, pg_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic [ADDR_W-1:0] raddr_reg;
    logic              m_valid_reg, m_valid_next;
    logic [7:0]        out_reg;

    logic [7:0]        eff_x, eff_y;
    logic              live;
    logic [7:0]        gcol, mask, val;
    logic [4:0]        pk;
    logic [8:0]        py, gy_end, prow;
    logic [6:0]        px;
    logic [ADDR_W-1:0] draw_addr, waddr, raddr;
    logic [7:0]        wdata, rdata;
    logic              we, re;

    assign eff_x = s_start_string ? s_x : cur_x_reg;
    assign eff_y = s_start_string ? s_y : cur_y_reg;
    assign live  = s_start_string || active_reg;

    assign sts.op        = s_op;
    assign sts.go        = live && (s_char_code != 8'd0)
                           && ({1'b0, eff_x} <= 9'(PANEL_WIDTH - GLYPH_COLS))
                           && ({1'b0, eff_y} <= 9'(PANEL_HEIGHT - GLYPH_HEIGHT));
    assign sts.clr_last  = (clr_reg == ADDR_W'(STORE_DEPTH - 1));
    assign sts.draw_last = (col_reg == 3'(GLYPH_COLS - 1)) && pg_reg;
    assign sts.mask_zero = (mask == 8'd0) || (pk > 5'd7);
    assign sts.out_free  = !m_valid_reg || m_ready;

    // page bytes touched by the current glyph column
    always_comb begin
        gcol   = FONT[gidx_reg][col_reg];
        pk     = gy_reg[7:3] + {4'd0, pg_reg};
        gy_end = {1'b0, gy_reg} + 9'(GLYPH_HEIGHT);
        mask   = '0;
        val    = '0;
        py     = '0;
        prow   = '0;
        for (int j = 0; j < 8; j++) begin
            py   = {1'b0, pk, 3'(j)};
            prow = py - {1'b0, gy_reg};
            if (py >= {1'b0, gy_reg} && py < gy_end) begin
                mask[7-j] = 1'b1;
                val[7-j]  = gcol[prow[2:0]];
            end
        end
        px        = 7'(gx_reg + 8'(col_reg));
        draw_addr = {px, 3'd7 - pk[2:0]};
    end

    assign we    = cmd.clr_wr || cmd.wr_draw;
    assign waddr = cmd.clr_wr ? clr_reg : draw_addr;
    assign wdata = cmd.clr_wr ? 8'd0 : ((rdata & ~mask) | (val & mask));
    assign re    = cmd.rd_req || cmd.rd_draw;
    assign raddr = cmd.rd_draw ? draw_addr : raddr_reg;

    tpfb_ram #(.WIDTH(STORE_WIDTH), .DEPTH(STORE_DEPTH)) u_store (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb begin
        cur_x_next   = cur_x_reg;
        cur_y_next   = cur_y_reg;
        active_next  = active_reg;
        col_next     = col_reg;
        pg_next      = pg_reg;
        clr_next     = clr_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (cmd.accept && s_op == OP_DRAW) begin
            if (s_start_string) begin
                cur_x_next = s_x;
                cur_y_next = s_y;
            end
            if (live) begin
                active_next = sts.go;
                if (sts.go) cur_x_next = eff_x + 8'(GLYPH_ADVANCE);
            end
            col_next = '0;
            pg_next  = 1'b0;
        end
        if (cmd.accept && s_op == OP_CLEAR) clr_next = '0;
        if (cmd.clr_wr) clr_next = clr_reg + ADDR_W'(1);
        if (cmd.step) begin
            pg_next = !pg_reg;
            if (pg_reg) col_next = col_reg + 3'd1;
        end
        if (cmd.out_load) m_valid_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_x_reg   <= '0;
            cur_y_reg   <= '0;
            active_reg  <= 1'b0;
            col_reg     <= '0;
            pg_reg      <= 1'b0;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            cur_x_reg   <= cur_x_next;
            cur_y_reg   <= cur_y_next;
            active_reg  <= active_next;
            col_reg     <= col_next;
            pg_reg      <= pg_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            gx_reg    <= eff_x;
            gy_reg    <= eff_y;
            gidx_reg  <= glyph_index(s_char_code);
            raddr_reg <= {s_read_column, s_read_page};
        end
        if (cmd.out_load) out_reg <= rdata;
    end

    assign m_valid     = m_valid_reg;
    assign m_read_byte = out_reg;
endmodule

[design/text_to_page_frame_buffer_core.sv]
`timescale 1ns / 1ps
// Top level of the text-to-page frame buffer: controller plus datapath.
// Depends on tpfb_pkg, tpfb_ctrl, tpfb_dp.
// After reset the block sweeps the 1024-byte store to zero, one byte per
// cycle, with s_ready low. One item is worked at a time. A read passes
// ST_RD_REQ and ST_RD_OUT, waiting there for a free output register, to a
// result word held in the output register while the next item is taken. A
// clear sweeps the store to zero like the reset sweep. A character does a
// read-modify-write of up to ten store bytes: ST_DRAW_RD, ST_DRAW_WR per
// byte, ST_DRAW_RD alone if skipped. Dropped/ended strings write nothing.
module text_to_page_frame_buffer_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_op,
    input  logic       s_start_string,
    input  logic [7:0] s_x,
    input  logic [7:0] s_y,
    input  logic [7:0] s_char_code,
    input  logic [6:0] s_read_column,
    input  logic [2:0] s_read_page,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_read_byte
);
    import tpfb_pkg::*;

    tpfb_cmd_t    cmd;
    tpfb_status_t sts;

    tpfb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    tpfb_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_op           (s_op),
        .s_start_string (s_start_string),
        .s_x            (s_x),
        .s_y            (s_y),
        .s_char_code    (s_char_code),
        .s_read_column  (s_read_column),
        .s_read_page    (s_read_page),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_read_byte    (m_read_byte),
        .cmd            (cmd),
        .sts            (sts)
    );
endmodule

[design/tpfb_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the frame buffer core, bound to the top level.
// Depends on tpfb_pkg and text_to_page_frame_buffer_core.
module tpfb_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic [1:0] s_op,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_read_byte
);
    import tpfb_pkg::*;

    a_reset_sweep: assert property (@(posedge aclk) !aresetn |=> !s_ready)
        else $error("ready right after reset");

    a_clear_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_op == OP_CLEAR |=> !s_ready)
        else $error("ready during clear");

    a_read_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_op == OP_READ |=> !s_ready)
        else $error("ready during read");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_read_byte))
        else $error("result word dropped or changed");
endmodule

bind text_to_page_frame_buffer_core tpfb_checker u_tpfb_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_op        (s_op),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_read_byte (m_read_byte)
);
